FILE: rtl/wdve_pkg.sv
package wdve_pkg;

    localparam int NUM_W = 25;
    localparam int CODE_W = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [NUM_W-1:0] CODE_AAAAA = 25'd1082401;
    localparam logic [NUM_W-1:0] CODE_END = 25'd28142427;
    localparam logic [CODE_W-1:0] THREE_BYTE_MARK = 24'hC00000;
    localparam logic [1:0] TWO_BYTE_MARK = 2'b10;

    localparam logic ACTION_WORD = 1'b0;
    localparam logic ACTION_FINISH = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] letter0;
        logic [7:0] letter1;
        logic [7:0] letter2;
        logic [7:0] letter3;
        logic [7:0] letter4;
    } word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       range_error;
    } code_t;

    typedef struct packed {
        logic [CODE_W-1:0] value;
        logic [1:0]        count;
        logic              err;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] byte_sel(input logic [CODE_W-1:0] v, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd2:    b = v[23:16];
            2'd1:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/word_delta_varint_encoder.sv
// A word is written into the queue; the byte serializer then pops it and registers its first byte for output.
// Throughput: one byte per cycle while code_stall is low; an item gives 1 to 3 bytes, set by its code length,
// and is sent by the byte serializer, while the queue lets the front take words until it is full.
// Reset: the previous word number returns to the code of aaaaa, queue and output empty.
module word_delta_varint_encoder #(
    parameter int QUEUE_DEPTH = wdve_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              word_valid,
    output logic              word_stall,
    input  wdve_pkg::word_t   word,
    output logic              code_valid,
    input  logic              code_stall,
    output wdve_pkg::code_t   code
);

    wdve_pkg::queue_status_t status;
    wdve_pkg::entry_t        push_entry;
    wdve_pkg::entry_t        head;
    logic                    push;
    logic                    pop;

    wdve_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word       (word),
        .status     (status),
        .push       (push),
        .entry      (push_entry)
    );

    wdve_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (push_entry),
        .pop    (pop),
        .rdata  (head),
        .status (status)
    );

    wdve_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .head       (head),
        .pop        (pop),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code)
    );

endmodule

FILE: rtl/wdve_front.sv
module wdve_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    output logic                  word_stall,
    input  wdve_pkg::word_t       word,
    input  wdve_pkg::queue_status_t status,
    output logic                  push,
    output wdve_pkg::entry_t      entry
);

    logic [wdve_pkg::NUM_W-1:0] prev_reg;
    logic [wdve_pkg::NUM_W-1:0] prev_next;
    logic [wdve_pkg::NUM_W-1:0] cur;
    logic [wdve_pkg::NUM_W:0]   diff;
    logic [7:0]                 letters [5];

    assign letters[0] = word.letter0;
    assign letters[1] = word.letter1;
    assign letters[2] = word.letter2;
    assign letters[3] = word.letter3;
    assign letters[4] = word.letter4;

    assign word_stall = status.full;
    assign push = word_valid && !status.full;

    always_comb
    begin
        cur = '0;
        for (int i = 0; i < 5; i++)
        begin
            if (letters[i] >= 8'h61 && letters[i] <= 8'h7A)
            begin
                cur = {cur[wdve_pkg::NUM_W-6:0], letters[i][4:0]};
            end
        end
    end

    always_comb
    begin
        if (word.action == wdve_pkg::ACTION_FINISH)
        begin
            diff = {1'b0, wdve_pkg::CODE_END} - {1'b0, prev_reg};
        end
        else
        begin
            diff = {1'b0, cur} - {1'b0, prev_reg};
        end
    end

    always_comb
    begin
        entry.value = diff[23:0] + wdve_pkg::THREE_BYTE_MARK;
        entry.count = 2'd3;
        entry.err = diff[25] || (diff[24:22] != 3'd0);
        prev_next = cur;
        if (word.action == wdve_pkg::ACTION_FINISH)
        begin
            prev_next = wdve_pkg::CODE_AAAAA;
        end
        else if (diff[25])
        begin
            entry.value = {16'd0, diff[7:0]};
            entry.count = 2'd1;
            entry.err = 1'b1;
        end
        else if (diff[24:7] == '0)
        begin
            entry.value = {16'd0, diff[7:0]};
            entry.count = 2'd1;
            entry.err = 1'b0;
        end
        else if (diff[24:14] == '0)
        begin
            entry.value = {8'd0, wdve_pkg::TWO_BYTE_MARK, diff[13:0]};
            entry.count = 2'd2;
            entry.err = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= wdve_pkg::CODE_AAAAA;
        end
        else if (push)
        begin
            prev_reg <= prev_next;
        end
    end

endmodule

FILE: rtl/wdve_fifo.sv
module wdve_fifo #(
    parameter int DEPTH = wdve_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  wdve_pkg::entry_t        wdata,
    input  logic                    pop,
    output wdve_pkg::entry_t        rdata,
    output wdve_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wdve_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              do_push;
    logic              do_pop;

    assign status.full = (cnt_reg == FULL_CNT);
    assign status.empty = (cnt_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop = pop && !status.empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");
`endif

endmodule

FILE: rtl/wdve_back.sv
module wdve_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  wdve_pkg::queue_status_t status,
    input  wdve_pkg::entry_t        head,
    output logic                    pop,
    output logic                    code_valid,
    input  logic                    code_stall,
    output wdve_pkg::code_t         code
);

    wdve_pkg::entry_t ent_reg;
    wdve_pkg::entry_t ent_next;
    logic [1:0]       rem_reg;
    logic [1:0]       rem_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    wdve_pkg::code_t  out_reg;
    wdve_pkg::code_t  out_next;
    logic             advance;

    assign advance = !out_valid_reg || !code_stall;
    assign code_valid = out_valid_reg;
    assign code = out_reg;

    always_comb
    begin
        pop = 1'b0;
        ent_next = ent_reg;
        rem_next = rem_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        if (advance)
        begin
            if (rem_reg != 2'd0)
            begin
                out_valid_next = 1'b1;
                out_next.out_byte = wdve_pkg::byte_sel(ent_reg.value, rem_reg - 2'd1);
                out_next.last_byte = (rem_reg == 2'd1);
                out_next.range_error = ent_reg.err;
                rem_next = rem_reg - 2'd1;
            end
            else if (!status.empty)
            begin
                pop = 1'b1;
                ent_next = head;
                out_valid_next = 1'b1;
                out_next.out_byte = wdve_pkg::byte_sel(head.value, head.count - 2'd1);
                out_next.last_byte = (head.count == 2'd1);
                out_next.range_error = head.err;
                rem_next = head.count - 2'd1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_rem_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != 2'd0) |-> out_valid_reg)
        else $error("bytes pending without a presented byte");

    a_not_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last_byte) |-> (rem_reg != 2'd0))
        else $error("non-final byte with nothing left to send");
`endif

endmodule
